// ===== hdl/pia_pkg.sv =====
// Package for the position integrator: request types, register indexes and widths.
`default_nettype none
package pia_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned LIM_W           = 31;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned LOOP_TIME_MS_DEF = 5;

  typedef enum logic {
    ACT_RESTART = 1'b0,
    ACT_TICK    = 1'b1
  } pia_action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANGE_LIMIT   = 3'd0,
    REG_DEAD_ZONE      = 3'd1,
    REG_ACTIVE_UPPER   = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_STALL_SPEED    = 3'd4,
    REG_STALL_TICKS    = 3'd5
  } pia_reg_e;

  typedef struct packed {
    logic                     action;
    logic                     hold;
    logic [DATA_W-1:0]        wall_ticks;
    logic signed [DATA_W-1:0] pos_error;
    logic signed [DATA_W-1:0] goal_error;
    logic signed [DATA_W-1:0] speed_meas;
    logic signed [DATA_W-1:0] speed_goal;
  } pia_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] integral_out;
    logic [DATA_W-1:0]        ref_time;
    logic                     is_paused;
    logic                     stall_flag;
  } pia_out_t;

endpackage
`default_nettype wire

// ===== hdl/position_integrator_antiwindup.sv =====
// Position-loop integral term with anti-windup, pause/resume and stall detection.
//
//  Channel  Signals                              Direction  Moves
//  in       in_valid_i, in_stall_o, in_data_i    to block   one request (restart or tick)
//  out      out_valid_o, out_stall_i, out_data_o from block one result per request
//  cfg      cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i  to block  register writes
//
// Each request is held in the input register and then moves into the result register
// while the integrator state updates; one request is taken every cycle while the output
// is not stalled. The limit on rate is the combinational state update
// (multiply by the loop time, add, clamp). Reset clears the valid flags, the integrator
// state and the configuration registers to zero with the block paused. A stall on the
// output holds both stages in place and stalls the input once the input register is full.
`default_nettype none
module position_integrator_antiwindup #(
  parameter int unsigned LOOP_TIME_MS = pia_pkg::LOOP_TIME_MS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire pia_pkg::pia_in_t                  in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output pia_pkg::pia_out_t                      out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pia_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pia_pkg::DATA_W-1:0]        cfg_data_i
);
  import pia_pkg::*;

  localparam int unsigned LOOP_W = $clog2(LOOP_TIME_MS + 1);
  localparam int unsigned PROD_W = DATA_W + LOOP_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam logic [LOOP_W-1:0] LOOP_K = LOOP_W'(LOOP_TIME_MS);

  // Configuration registers.
  logic [LIM_W-1:0]  change_limit_q, dead_zone_q, active_upper_q;
  logic [LIM_W-1:0]  integral_limit_q, stall_speed_q;
  logic [DATA_W-1:0] stall_ticks_q;

  // Integrator state.
  logic signed [DATA_W-1:0] accum_q, accum_d;
  logic                     running_q, running_d;
  logic [DATA_W-1:0]        pause_start_q, pause_start_d;
  logic [DATA_W-1:0]        paused_total_q, paused_total_d;

  // Pipeline registers.
  pia_in_t  in_q;
  logic     in_valid_q;
  pia_out_t out_q, out_d;
  logic     out_valid_q;
  logic     advance;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      change_limit_q   <= '0;
      dead_zone_q      <= '0;
      active_upper_q   <= '0;
      integral_limit_q <= '0;
      stall_speed_q    <= '0;
      stall_ticks_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CHANGE_LIMIT:   change_limit_q   <= cfg_data_i[LIM_W-1:0];
        REG_DEAD_ZONE:      dead_zone_q      <= cfg_data_i[LIM_W-1:0];
        REG_ACTIVE_UPPER:   active_upper_q   <= cfg_data_i[LIM_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_data_i[LIM_W-1:0];
        REG_STALL_SPEED:    stall_speed_q    <= cfg_data_i[LIM_W-1:0];
        REG_STALL_TICKS:    stall_ticks_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the result register frees when empty or being taken.
  assign advance     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance && in_valid_q) begin
      out_q <= out_d;
    end
  end

  // Integrator datapath.
  logic                     is_tick;
  logic signed [DATA_W-1:0] lim_pos, lim_neg, err_clip;
  logic signed [PROD_W-1:0] prod_raw, prod_clip;
  logic signed [SUM_W-1:0]  accum_ext, sum_raw, sum_clip, sum_sel, v_sum, il_pos, il_neg;
  logic [SUM_W-1:0]         mag_accum, mag_raw, mag_clip;
  logic                     dec_raw, dec_fin, in_window;
  logic [DATA_W:0]          goal_mag, accum_new_mag;
  logic signed [DATA_W-1:0] clamped;
  logic signed [DATA_W:0]   ref_ext, spd_ext, ref_abs, spd_adj;
  logic                     sat, fast_move, elapsed_ok, stall;
  logic [DATA_W-1:0]        stall_end, since_end;

  always_comb begin
    is_tick = (in_q.action == ACT_TICK);

    lim_pos  = $signed({1'b0, change_limit_q});
    lim_neg  = -lim_pos;
    if (in_q.pos_error > lim_pos) begin
      err_clip = lim_pos;
    end else if (in_q.pos_error < lim_neg) begin
      err_clip = lim_neg;
    end else begin
      err_clip = in_q.pos_error;
    end

    prod_raw  = $signed(PROD_W'(in_q.pos_error)) * $signed({1'b0, LOOP_K});
    prod_clip = $signed(PROD_W'(err_clip)) * $signed({1'b0, LOOP_K});

    accum_ext = SUM_W'(accum_q);
    sum_raw   = accum_ext + SUM_W'(prod_raw);
    sum_clip  = accum_ext + SUM_W'(prod_clip);

    mag_accum = accum_ext[SUM_W-1] ? $unsigned(-accum_ext) : $unsigned(accum_ext);
    mag_raw   = sum_raw[SUM_W-1] ? $unsigned(-sum_raw) : $unsigned(sum_raw);
    mag_clip  = sum_clip[SUM_W-1] ? $unsigned(-sum_clip) : $unsigned(sum_clip);

    // A step that shrinks the magnitude is always taken and is never clipped.
    dec_raw = mag_raw < mag_accum;
    dec_fin = dec_raw || (mag_clip < mag_accum);
    sum_sel = dec_raw ? sum_raw : sum_clip;

    goal_mag  = in_q.goal_error[DATA_W-1] ? $unsigned(-(DATA_W+1)'(in_q.goal_error))
                                          : $unsigned((DATA_W+1)'(in_q.goal_error));
    in_window = (goal_mag >= (DATA_W+1)'(dead_zone_q))
             && (goal_mag <= (DATA_W+1)'(active_upper_q));

    v_sum  = (in_window || dec_fin) ? sum_sel : accum_ext;
    il_pos = $signed(SUM_W'(integral_limit_q));
    il_neg = -il_pos;
    if (v_sum > il_pos) begin
      clamped = DATA_W'(il_pos);
    end else if (v_sum < il_neg) begin
      clamped = DATA_W'(il_neg);
    end else begin
      clamped = DATA_W'(v_sum);
    end

    // State update. A restart clears and runs; a hold tick pauses, other ticks resume.
    if (!is_tick) begin
      running_d      = 1'b1;
      pause_start_d  = in_q.wall_ticks;
      paused_total_d = '0;
      accum_d        = '0;
    end else begin
      running_d      = !in_q.hold;
      pause_start_d  = (in_q.hold && running_q) ? in_q.wall_ticks : pause_start_q;
      paused_total_d = (!in_q.hold && !running_q)
                     ? paused_total_q + (in_q.wall_ticks - pause_start_q)
                     : paused_total_q;
      accum_d        = (!running_d && !dec_raw) ? accum_q : clamped;
    end

    // Stall check on the updated state.
    accum_new_mag = accum_d[DATA_W-1] ? $unsigned(-(DATA_W+1)'(accum_d))
                                      : $unsigned((DATA_W+1)'(accum_d));
    sat = (integral_limit_q != '0) && (accum_new_mag >= (DATA_W+1)'(integral_limit_q));

    ref_ext = (DATA_W+1)'(in_q.speed_goal);
    spd_ext = (DATA_W+1)'(in_q.speed_meas);
    if (ref_ext < 0) begin
      ref_abs = -ref_ext;
      spd_adj = -spd_ext;
    end else begin
      ref_abs = ref_ext;
      spd_adj = spd_ext;
    end
    fast_move = (ref_abs != '0) && (spd_adj > $signed({2'b00, stall_speed_q}));

    stall_end  = pause_start_d + stall_ticks_q;
    since_end  = in_q.wall_ticks - stall_end;
    elapsed_ok = since_end < 32'h7FFF_FFFF;
    stall      = !(running_d && !sat) && !fast_move && elapsed_ok;

    out_d.integral_out = accum_d;
    out_d.ref_time     = (running_d ? in_q.wall_ticks : pause_start_d) - paused_total_d;
    out_d.is_paused    = !running_d;
    out_d.stall_flag   = stall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q        <= '0;
      running_q      <= 1'b0;
      pause_start_q  <= '0;
      paused_total_q <= '0;
    end else if (advance && in_valid_q) begin
      accum_q        <= accum_d;
      running_q      <= running_d;
      pause_start_q  <= pause_start_d;
      paused_total_q <= paused_total_d;
    end
  end

  // The result register always shows the state that its request left behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q |=> out_q.integral_out == accum_q && out_q.is_paused == !running_q)
    else $error("result does not match integrator state");

  // A restart leaves a zero integral, running, and no stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && in_q.action == ACT_RESTART
    |=> out_q.integral_out == '0 && !out_q.is_paused && !out_q.stall_flag
        && paused_total_q == '0)
    else $error("restart did not clear the integrator");

  // Pausing while already paused keeps the recorded pause start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && in_q.action == ACT_TICK && in_q.hold && !running_q
    |=> pause_start_q == $past(pause_start_q) && paused_total_q == $past(paused_total_q))
    else $error("repeated pause moved the pause bookkeeping");

  // State only moves when a request passes into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && in_valid_q) |=> $stable(accum_q) && $stable(running_q))
    else $error("integrator state changed without a request");

endmodule
`default_nettype wire

// ===== tb/position_integrator_antiwindup_check.sv =====
// Watches the three channels of the position integrator, predicts each result and compares it.
module position_integrator_antiwindup_check #(
  parameter int unsigned LOOP_TIME_MS = pia_pkg::LOOP_TIME_MS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  pia_pkg::pia_in_t                in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  pia_pkg::pia_out_t               out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [pia_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pia_pkg::DATA_W-1:0]      cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import pia_pkg::*;

  logic [LIM_W-1:0]         change_limit_q;
  logic [LIM_W-1:0]         dead_zone_q;
  logic [LIM_W-1:0]         active_upper_q;
  logic [LIM_W-1:0]         integral_limit_q;
  logic [LIM_W-1:0]         stall_speed_q;
  logic [DATA_W-1:0]        stall_ticks_q;

  logic signed [DATA_W-1:0] accum_q;
  logic                     running_q;
  logic [DATA_W-1:0]        pause_start_q;
  logic [DATA_W-1:0]        paused_total_q;

  pia_out_t                 due_results[$];
  int unsigned              fail_total;
  int unsigned              checked_total;

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit step_shrinks(longint acc, longint err);
    return magnitude(acc + err * longint'(LOOP_TIME_MS)) < magnitude(acc);
  endfunction

  // Advances the integrator state by one request and returns the result it produces.
  function automatic pia_out_t integrate_request(pia_in_t req);
    pia_out_t          res;
    logic [DATA_W-1:0] t;
    logic [DATA_W-1:0] elapsed;
    longint            err;
    longint            goal;
    longint            lim;
    longint            v;
    longint            spd;
    longint            spd_ref;
    bit                dec;
    bit                sat;
    bit                stall;
    t       = req.wall_ticks;
    err     = longint'($signed(req.pos_error));
    goal    = longint'($signed(req.goal_error));
    spd     = longint'($signed(req.speed_meas));
    spd_ref = longint'($signed(req.speed_goal));
    if (req.action == ACT_RESTART) begin
      accum_q        = '0;
      paused_total_q = '0;
      pause_start_q  = t;
      running_q      = 1'b1;
    end else begin
      if (req.hold) begin
        if (running_q) begin
          running_q     = 1'b0;
          pause_start_q = t;
        end
      end else if (!running_q) begin
        running_q      = 1'b1;
        paused_total_q = paused_total_q + (t - pause_start_q);
      end
      dec = step_shrinks(longint'(accum_q), err);
      if (running_q || dec) begin
        // Growth is limited per tick; a clipped step may turn into a shrinking one.
        if (!dec) begin
          lim = longint'(change_limit_q);
          if (err > lim) err = lim;
          if (err < -lim) err = -lim;
          dec = step_shrinks(longint'(accum_q), err);
        end
        v = longint'(accum_q);
        if ((magnitude(goal) >= longint'(dead_zone_q) &&
             magnitude(goal) <= longint'(active_upper_q)) || dec) begin
          v = v + err * longint'(LOOP_TIME_MS);
        end
        lim = longint'(integral_limit_q);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        accum_q = v[DATA_W-1:0];
      end
    end

    sat = (integral_limit_q != '0) &&
          (magnitude(longint'(accum_q)) >= longint'(integral_limit_q));
    if (running_q && !sat) begin
      stall = 1'b0;
    end else begin
      if (spd_ref < 0) begin
        spd_ref = -spd_ref;
        spd     = -spd;
      end
      if (spd_ref != 0 && spd > longint'(stall_speed_q)) begin
        stall = 1'b0;
      end else begin
        // Differences of 2^31 - 1 or more count as not yet elapsed.
        elapsed = t - (pause_start_q + stall_ticks_q);
        stall   = elapsed < 32'h7FFF_FFFF;
      end
    end

    res.integral_out = accum_q;
    res.ref_time     = (running_q ? t : pause_start_q) - paused_total_q;
    res.is_paused    = !running_q;
    res.stall_flag   = stall;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pia_out_t want;
    pia_out_t got;
    if (!rst_ni) begin
      change_limit_q   = '0;
      dead_zone_q      = '0;
      active_upper_q   = '0;
      integral_limit_q = '0;
      stall_speed_q    = '0;
      stall_ticks_q    = '0;
      accum_q          = '0;
      running_q        = 1'b0;
      pause_start_q    = '0;
      paused_total_q   = '0;
      due_results.delete();
      fail_total       = 0;
      checked_total    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_CHANGE_LIMIT:   change_limit_q   = cfg_data_i[LIM_W-1:0];
          REG_DEAD_ZONE:      dead_zone_q      = cfg_data_i[LIM_W-1:0];
          REG_ACTIVE_UPPER:   active_upper_q   = cfg_data_i[LIM_W-1:0];
          REG_INTEGRAL_LIMIT: integral_limit_q = cfg_data_i[LIM_W-1:0];
          REG_STALL_SPEED:    stall_speed_q    = cfg_data_i[LIM_W-1:0];
          REG_STALL_TICKS:    stall_ticks_q    = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (due_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_total++;
        end else begin
          want = due_results.pop_front();
          checked_total++;
          if (got.integral_out !== want.integral_out) begin
            $error("integral_out: expected %0d, got %0d",
                   $signed(want.integral_out), $signed(got.integral_out));
            fail_total++;
          end
          if (got.ref_time !== want.ref_time) begin
            $error("ref_time: expected %0d, got %0d", want.ref_time, got.ref_time);
            fail_total++;
          end
          if (got.is_paused !== want.is_paused) begin
            $error("is_paused: expected %0b, got %0b", want.is_paused, got.is_paused);
            fail_total++;
          end
          if (got.stall_flag !== want.stall_flag) begin
            $error("stall_flag: expected %0b, got %0b", want.stall_flag, got.stall_flag);
            fail_total++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(integrate_request(in_data_i));
      end
    end
    fail_count_o <= fail_total;
    pending_o    <= due_results.size();
    checked_o    <= checked_total;
  end

endmodule

// ===== tb/position_integrator_antiwindup_test.sv =====
// Stimulus and verdict for the position integrator with anti-windup, pause and stall check.
module position_integrator_antiwindup_test;
  import pia_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_ITEMS  = 1600;
  localparam int unsigned BLOCK_ITEMS   = 200;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam logic [DATA_W-1:0] MAX31  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN32  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ALL1   = 32'hFFFF_FFFF;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  pia_in_t               in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pia_out_t              out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [DATA_W-1:0]     cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycle_count  = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned restarts     = 0;
  int unsigned ticks        = 0;
  int unsigned settings     = 0;

  // Register values as the block holds them after each write, used only to aim the stimulus.
  logic [DATA_W-1:0] cl_set, dz_set, au_set, il_set, ss_set, st_set;
  // Time base and pause tracking for well-formed request sequences.
  logic [DATA_W-1:0] clock_now = '0;
  logic [DATA_W-1:0] pause_at  = '0;
  bit                hold_req     = 1'b0;
  bit                paused_stim  = 1'b0;
  bit                need_restart = 1'b1;

  position_integrator_antiwindup uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  position_integrator_antiwindup_check integ_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("position_integrator_antiwindup test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
  end

  task automatic push_request(input pia_in_t req);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req.action == ACT_RESTART) restarts++;
    else ticks++;
  endtask

  task automatic send(input logic act, input logic hold, input logic [DATA_W-1:0] t,
                      input logic [DATA_W-1:0] pos, input logic [DATA_W-1:0] goal,
                      input logic [DATA_W-1:0] sm, input logic [DATA_W-1:0] sg);
    pia_in_t req;
    req.action     = act;
    req.hold       = hold;
    req.wall_ticks = t;
    req.pos_error  = pos;
    req.goal_error = goal;
    req.speed_meas = sm;
    req.speed_goal = sg;
    push_request(req);
  endtask

  // Holds off new requests until every outstanding result is back and the pipe is empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [DATA_W-1:0] cl, input logic [DATA_W-1:0] dz,
                               input logic [DATA_W-1:0] au, input logic [DATA_W-1:0] il,
                               input logic [DATA_W-1:0] ss, input logic [DATA_W-1:0] st);
    // The unmapped index must be ignored by the block.
    write_reg(REG_UNMAPPED, $urandom());
    write_reg(REG_CHANGE_LIMIT, cl);
    write_reg(REG_DEAD_ZONE, dz);
    write_reg(REG_ACTIVE_UPPER, au);
    write_reg(REG_INTEGRAL_LIMIT, il);
    write_reg(REG_STALL_SPEED, ss);
    write_reg(REG_STALL_TICKS, st);
    cfg_valid_i <= 1'b0;
    cl_set = {1'b0, cl[LIM_W-1:0]};
    dz_set = {1'b0, dz[LIM_W-1:0]};
    au_set = {1'b0, au[LIM_W-1:0]};
    il_set = {1'b0, il[LIM_W-1:0]};
    ss_set = {1'b0, ss[LIM_W-1:0]};
    st_set = st;
    settings++;
  endtask

  function automatic logic [DATA_W-1:0] pick_setting();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 100);
      1:       return $urandom_range(0, 100000);
      2:       return $urandom();
      default: return MAX31;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] widen(logic [DATA_W-1:0] x);
    return (x >= 32'h3FFF_FFFB) ? MAX31 : x * 2 + 10;
  endfunction

  // Signed value with its magnitude mostly in [lo, hi], sometimes an extreme or noise.
  function automatic logic [DATA_W-1:0] pick_signed(logic [DATA_W-1:0] lo,
                                                    logic [DATA_W-1:0] hi);
    logic [DATA_W-1:0] m;
    case ($urandom_range(0, 9))
      0: return MIN32;
      1: return MAX31;
      2: return $urandom();
      3: return '0;
      default: begin
        m = $urandom_range(lo, hi);
        return $urandom_range(0, 1) ? -m : m;
      end
    endcase
  endfunction

  function automatic pia_in_t random_request();
    pia_in_t     req;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6 && !need_restart) begin
      req.action     = 1'($urandom_range(0, 1));
      req.hold       = 1'($urandom_range(0, 1));
      req.wall_ticks = $urandom();
      req.pos_error  = $urandom();
      req.goal_error = $urandom();
      req.speed_meas = $urandom();
      req.speed_goal = $urandom();
      return req;
    end
    if (need_restart || roll < 9) begin
      need_restart = 1'b0;
      clock_now    = $urandom();
      paused_stim  = 1'b0;
      hold_req     = 1'b0;
      req.action   = ACT_RESTART;
      req.hold     = 1'($urandom_range(0, 1));
    end else begin
      if ($urandom_range(0, 99) < 6) hold_req = !hold_req;
      // While paused, sometimes land right at the edge of the stall delay.
      if (paused_stim && $urandom_range(0, 9) == 0)
        clock_now = pause_at + st_set + $urandom_range(0, 4) - 2;
      else if (roll < 12)
        clock_now = clock_now + $urandom();
      else
        clock_now = clock_now + $urandom_range(1, 12);
      if (hold_req && !paused_stim) pause_at = clock_now;
      paused_stim = hold_req;
      req.action  = ACT_TICK;
      req.hold    = hold_req;
    end
    req.wall_ticks = clock_now;
    req.pos_error  = pick_signed('0, widen(cl_set));
    req.goal_error = (dz_set <= au_set) ? pick_signed(dz_set, au_set)
                                        : pick_signed('0, widen(au_set));
    req.speed_meas = pick_signed('0, widen(ss_set));
    req.speed_goal = pick_signed('0, widen(ss_set));
    return req;
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero settings: the clamp holds the integral at zero; the first tick resumes
    // from the paused reset state.
    load_settings('0, '0, '0, '0, '0, '0);
    send(ACT_TICK, 1'b0, 32'd7, 32'd1000, '0, '0, '0);
    send(ACT_TICK, 1'b1, 32'd9, MIN32, MIN32, MIN32, MIN32);
    send(ACT_RESTART, 1'b1, ALL1, MAX31, MAX31, MAX31, MAX31);
    drain();

    load_settings(32'd1000, 32'd10, 32'd100000, 32'd1000000, 32'd50, 32'd20);
    send(ACT_RESTART, 1'b0, 32'd100, '0, '0, '0, '0);
    send(ACT_TICK, 1'b0, 32'd105, 32'd500, 32'd50, '0, '0);
    // Growth clipped to the change limit, then a shrinking step clipped and taken.
    send(ACT_TICK, 1'b0, 32'd110, MAX31, -32'sd50, '0, '0);
    send(ACT_TICK, 1'b0, 32'd115, MIN32, 32'd50, '0, '0);
    // Goal error below the dead zone, then above the window but shrinking.
    send(ACT_TICK, 1'b0, 32'd120, 32'd100, 32'd5, '0, '0);
    send(ACT_TICK, 1'b0, 32'd125, -32'sd100, MIN32, '0, '0);
    // Pause, pause again, shrink while paused, then stall timing at its edges.
    send(ACT_TICK, 1'b1, 32'd200, 32'd100, 32'd50, '0, '0);
    send(ACT_TICK, 1'b1, 32'd210, 32'd100, 32'd50, '0, '0);
    send(ACT_TICK, 1'b1, 32'd215, -32'sd100, 32'd50, 32'd10, 32'd40);
    send(ACT_TICK, 1'b1, 32'd220, '0, 32'd50, 32'd50, 32'd40);
    send(ACT_TICK, 1'b1, 32'd220 + 32'h7FFF_FFFE, '0, 32'd50, -32'sd50, -32'sd40);
    send(ACT_TICK, 1'b1, 32'd220 + 32'h7FFF_FFFF, '0, 32'd50, '0, '0);
    send(ACT_TICK, 1'b0, 32'd300, 32'd10, 32'd50, -32'sd51, -32'sd40);
    // Pause and resume across the wrap of the time counter.
    send(ACT_RESTART, 1'b0, 32'hFFFF_FFF0, '0, '0, 32'd5, '0);
    send(ACT_TICK, 1'b1, 32'hFFFF_FFF8, '0, '0, '0, '0);
    send(ACT_TICK, 1'b0, 32'd8, '0, '0, '0, '0);
    drain();

    load_settings(MAX31, '0, MAX31, MAX31, '0, ALL1);
    send(ACT_RESTART, 1'b0, 32'd50, '0, '0, '0, '0);
    send(ACT_TICK, 1'b0, 32'd55, MAX31, '0, '0, '0);
    send(ACT_TICK, 1'b0, 32'd60, MIN32, '0, '0, '0);
    send(ACT_TICK, 1'b0, 32'd65, 32'd1, '0, 32'd1, 32'd1);
    drain();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        drain();
        if (n == 0)
          load_settings(MAX31, MAX31, MAX31, MAX31, MAX31, ALL1);
        else
          load_settings(pick_setting(), $urandom_range(0, 1) ? $urandom_range(0, 50)
                                                             : pick_setting(),
                        pick_setting(), pick_setting(), pick_setting(), pick_setting());
        need_restart = 1'b1;
      end
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 53;
        rx_idle_pct <= 8;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end else if (n == 0) begin
        tx_idle_pct = 8;
        rx_idle_pct <= 53;
      end
      push_request(random_request());
    end

    drain();
    $display("Ran %0d restarts and %0d ticks under %0d register settings;",
             restarts, ticks, settings);
    $display("%0d results compared, with idle gaps and output stalls on both sides.",
             checked);
    if (fail_count == 0) begin
      $display("position_integrator_antiwindup test passed");
    end else begin
      $display("position_integrator_antiwindup test failed");
    end
    $finish;
  end

endmodule
